// ----- rtl/leb_pkg.sv -----
`default_nettype none

package leb_pkg;

  // Width of the encoded value; bits of the input above it are ignored.
  localparam int VALUE_WIDTH = 64;

  // Longest encoding in bytes, and the width of the byte counter.
  localparam int MAX_BYTES = 10;
  localparam int CNT_W     = $clog2(MAX_BYTES);

  // Seven value bits per encoded byte.
  localparam int GROUP_W = 7;

  // Keeps the low VALUE_WIDTH bits of a 64-bit word.
  localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new value
    logic step;  // emit one byte into the output register
  } leb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;  // the byte being formed is the final one
  } leb_stat_t;

endpackage

`default_nettype wire

// ----- rtl/leb128_encoder_unit.sv -----
// LEB128 encoder: one value in, 1 to 10 bytes out, least significant group first.
// The value word is loaded into the shift register, and each byte then passes through the output register.
// Throughput: one byte per cycle while the receiver takes them; a new value is accepted
// only after the final byte of the last one has entered the output register.
// Reset (rst, synchronous) empties the output register and returns to idle.
`default_nettype none

module leb128_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] value
  input  wire logic        s_axis_tuser,   // [0] is_signed
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast
);
  import leb_pkg::*;

  leb_cmd_t  cmd;
  leb_stat_t stat;

  // Sequencing of loads and byte emission.
  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Shift register, stop test and output word register.
  leb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (s_axis_tdata),
    .is_signed (s_axis_tuser),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/leb_dp.sv -----
`default_nettype none

module leb_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire leb_pkg::leb_cmd_t  cmd,
  output leb_pkg::leb_stat_t      stat,
  input  wire logic [63:0]      value,
  input  wire logic             is_signed,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import leb_pkg::*;

  logic [63:0]      v;
  logic             sgn;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic             load_neg;
  logic [63:0]      v_load;
  logic [63:0]      v_shift;
  logic [GROUP_W-1:0] grp;
  logic             done;

  // Mask the value to its width and sign-extend it in signed mode.
  always_comb begin
    load_neg = is_signed & value[VALUE_WIDTH-1];
    v_load   = (value & WMASK) | (load_neg ? ~WMASK : 64'd0);
  end

  // Next seven-bit group, the shifted remainder and the stop test.
  always_comb begin
    grp     = v[GROUP_W-1:0];
    v_shift = {{GROUP_W{neg}}, v[63:GROUP_W]};
    if (sgn) begin
      if (neg) begin
        done = (v_shift == {64{1'b1}}) && grp[GROUP_W-1];
      end else begin
        done = (v_shift == 64'd0) && !grp[GROUP_W-1];
      end
    end else begin
      done = (v_shift == 64'd0);
    end
    if (cnt == CNT_W'(MAX_BYTES - 1)) begin
      done = 1'b1;
    end
  end

  assign stat.done = done;

  // Byte counter; it holds on the final byte so it never passes the longest code.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step && !done) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Value shift register and mode flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= v_load;
      sgn <= is_signed;
      neg <= load_neg;
    end else if (cmd.step) begin
      v <= v_shift;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte <= {~done, grp};
      out_last <= done;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_BYTES - 1))
    else $error("byte counter ran past the longest encoding");

  a_cont_bit: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (out_byte[7] != out_last))
    else $error("continuation bit disagrees with last marker");

  a_load_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cnt == '0))
    else $error("byte counter not cleared on a new value");
`endif

endmodule

`default_nettype wire

// ----- rtl/leb_ctrl.sv -----
`default_nettype none

module leb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output leb_pkg::leb_cmd_t      cmd,
  input  wire leb_pkg::leb_stat_t stat
);
  import leb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // The output register can take a word when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state == ST_RUN) && out_free;

  // State transitions.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> out_valid)
    else $error("emitted byte not presented");

  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && stat.done) |=> in_ready)
    else $error("controller did not return to idle after the final byte");

  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("new value taken while one is being encoded");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  import leb_pkg::*;

  // Run limit in clock cycles, far beyond the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed for stray words to show up after the last expected one.
  localparam int DRAIN_CYCLES = 24;

  // One expected output word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } enc_byte_t;

  // Scoreboard: encodes each accepted value and checks the bytes that come out.
  class leb_byte_checker;
    enc_byte_t pending_bytes[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Prints one mismatch line and counts it.
    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // Works out the LEB128 bytes of an accepted value and queues them.
    function void note_value(input logic [63:0] value, input logic is_signed);
      logic [63:0] rest;
      logic [6:0]  group;
      logic        neg;
      logic        done;
      int          count;
      enc_byte_t   entry;
      rest  = value & WMASK;
      neg   = 1'b0;
      done  = 1'b0;
      count = 0;
      if (is_signed) begin
        neg = rest[VALUE_WIDTH-1];
        if (neg) rest = rest | ~WMASK;
      end
      while (!done) begin
        group = rest[GROUP_W-1:0];
        // Arithmetic shift for negative signed values.
        rest = rest >> GROUP_W;
        if (neg) rest = rest | ~({64{1'b1}} >> GROUP_W);
        if (is_signed) begin
          if (neg) done = (rest == {64{1'b1}}) && group[GROUP_W-1];
          else     done = (rest == 64'd0) && !group[GROUP_W-1];
        end else begin
          done = (rest == 64'd0);
        end
        if (count + 1 >= MAX_BYTES) done = 1'b1;
        entry.out_byte = {!done, group};
        entry.last     = done;
        pending_bytes.push_back(entry);
        count++;
      end
    endfunction

    // Compares an accepted output word with the oldest expected byte.
    task check_byte(input logic [7:0] out_byte, input logic last);
      enc_byte_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected word %02h last %0b", out_byte, last));
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.out_byte)
          report($sformatf("byte %02h, expected %02h", out_byte, want.out_byte));
        if (last !== want.last)
          report($sformatf("last %0b, expected %0b", last, want.last));
      end
    endtask

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = 64'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  leb_byte_checker sb;
  int              cycles = 0;
  int              rx_max_gap = 13;
  bit              hold_req = 1'b0;

  leb128_encoder_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one value word after a random gap and waits until it is taken.
  task send_value(input logic [63:0] value, input logic is_signed, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= is_signed;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_value(value, is_signed);
  endtask

  // Random value with a random significant length, so that all encoding
  // lengths turn up; in signed mode about half of them are negative.
  task send_random(input int count, input int max_gap);
    logic [63:0] value;
    logic        is_signed;
    int          nbits;
    repeat (count) begin
      value     = {$urandom(), $urandom()};
      is_signed = 1'($urandom_range(0, 1));
      nbits     = $urandom_range(0, 64);
      if (nbits < 64) value = value & ((64'd1 << nbits) - 64'd1);
      if (is_signed && $urandom_range(0, 1)) value = ~value;
      send_value(value, is_signed, max_gap);
    end
  endtask

  // Stops offering values and waits until every expected byte has come out.
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Receiver: random stalls per word, plus the long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_byte(m_axis_tdata, m_axis_tlast);
    end
  end

  // Stimulus and end of run.
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed values: zero, minus one, sign boundaries and full-length codes.
    send_value(64'd0, 1'b0, 13);
    send_value(64'd0, 1'b1, 13);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 13);
    send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 13);
    send_value(64'd63, 1'b1, 13);
    send_value(64'd64, 1'b1, 13);
    send_value(64'd64, 1'b0, 13);
    send_value(64'hFFFF_FFFF_FFFF_FFC0, 1'b1, 13);
    send_value(64'hFFFF_FFFF_FFFF_FFBF, 1'b1, 13);
    send_value(64'd127, 1'b0, 13);
    send_value(64'd128, 1'b0, 13);
    send_value(64'd127, 1'b1, 13);
    send_value(64'd128, 1'b1, 13);
    send_value(64'h8000_0000_0000_0000, 1'b0, 13);
    send_value(64'h8000_0000_0000_0000, 1'b1, 13);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 13);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 13);
    send_value(64'h00FF_FFFF_FFFF_FFFF, 1'b0, 13);
    send_value(64'h0100_0000_0000_0000, 1'b1, 13);
    send_value(64'hFF00_0000_0000_0000, 1'b1, 13);
    send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 13);
    send_value(64'h5555_5555_5555_5555, 1'b1, 13);

    // Random values with idling on both sides.
    send_random(100, 13);
    wait_drained();

    // Receiver holds off while the sender keeps offering back to back.
    hold_req = 1'b1;
    send_random(20, 0);
    wait_drained();

    // No idling on either side.
    rx_max_gap = 0;
    send_random(90, 0);
    wait_drained();

    // Idling again on both sides.
    rx_max_gap = 13;
    send_random(90, 13);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/leb_pkg.sv
rtl/leb_dp.sv
rtl/leb_ctrl.sv
rtl/leb128_encoder_unit.sv
tb/tb_top.sv
